### rtl/assert_macros.svh
// Assertion macros; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/hmt_pkg.sv
`default_nettype none
package hmt_pkg;

  localparam int N_MAX_DEF      = 256;
  localparam int S_MAX_DEF      = 16;
  localparam int MATRIX_MAX_DEF = 256;
  localparam int CFG_W          = 9;

  localparam logic [1:0] OP_PY    = 2'd0;
  localparam logic [1:0] OP_VINVZ = 2'd1;
  localparam logic [1:0] OP_Z     = 2'd2;
  localparam logic [1:0] OP_ELEM  = 2'd3;

  localparam logic REG_SIZE_N      = 1'b0;
  localparam logic REG_PROBE_COUNT = 1'b1;

  localparam logic KIND_PROD  = 1'b0;
  localparam logic KIND_TRACE = 1'b1;

  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         row;
    logic [7:0]         column;
    logic [3:0]         probe;
    logic [7:0]         matrix_index;
    logic signed [31:0] value;
  } req_item_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         index;
    logic signed [63:0] result_value;
    logic               last;
  } rsp_item_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if (!a[63] && !b[63] && r[63]) begin
      return Q_MAX;
    end
    if (a[63] && b[63] && !r[63]) begin
      return Q_MIN;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/hmt_ifs.sv
`default_nettype none
interface hmt_req_if import hmt_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface hmt_rsp_if import hmt_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

### rtl/hmt_ram.sv
`default_nettype none
module hmt_ram import hmt_pkg::*; #(
  parameter int W     = 32,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [W-1:0]       rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/hmt_div.sv
`default_nettype none
module hmt_div import hmt_pkg::*; #(
  parameter int VW = 5
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic [VW-1:0]      divisor,
  output logic                    done,
  output logic signed [63:0]      quotient
);
  `include "assert_macros.svh"

  logic          busy;
  logic [5:0]    cnt;
  logic [VW:0]   rem;
  logic [63:0]   quo;
  logic          neg;
  logic [VW-1:0] dsr;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;

  assign shifted  = {rem[VW-1:0], quo[63]};
  assign ge       = shifted >= {1'b0, dsr};
  assign diff     = shifted - {1'b0, dsr};
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dsr  <= divisor;
        neg  <= dividend[63];
        quo  <= dividend[63] ? 64'(-dividend) : 64'(dividend);
      end else if (busy) begin
        rem <= ge ? diff : shifted;
        quo <= {quo[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `ASSERT_CLK(a_done_idle, done |-> !busy, "quotient flagged while still iterating")
  `ASSERT_CLK(a_start_busy, start |=> busy, "divide did not start")

endmodule
`default_nettype wire

### rtl/matvec_hutchinson_trace_core.sv
// Streaming K*py and trace estimator. Load requests (py, vinvz, z) are taken when idle.
// For a matrix element one probe column is read from the vinvz memory per cycle and
// multiply-accumulated. A row end issues the product element when the output register
// is free, then runs the z multiply per probe in TRD, TMAG, THI, TLO, TADD (split into
// two 32x32 partial products). A matrix end runs the bit-serial divide by s before the
// trace estimate is issued. Result items leave through a one-item output register.
// Store entries that were never loaded read back undefined.
`default_nettype none
module matvec_hutchinson_trace_core import hmt_pkg::*; #(
  parameter int N_MAX      = N_MAX_DEF,
  parameter int S_MAX      = S_MAX_DEF,
  parameter int MATRIX_MAX = MATRIX_MAX_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  hmt_req_if.sink               req,
  hmt_rsp_if.source             rsp,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);
  `include "assert_macros.svh"

  localparam int NW   = $clog2(N_MAX + 1);
  localparam int CW   = (NW > 9) ? NW : 9;
  localparam int PW   = $clog2(S_MAX + 1);
  localparam int SW   = (PW > 5) ? PW : 5;
  localparam int IXR  = $clog2(S_MAX);
  localparam int IX   = (IXR > 0) ? IXR : 1;
  localparam int AWR  = $clog2(N_MAX * S_MAX);
  localparam int AW   = (AWR > 0) ? AWR : 1;
  localparam int YWR  = $clog2(N_MAX);
  localparam int YW   = (YWR > 0) ? YWR : 1;
  localparam int XWR  = $clog2(MATRIX_MAX + 1);
  localparam int XW   = (XWR > 8) ? XWR : 8;
  localparam int SXW  = (PW > 4) ? PW : 4;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MAC  = 10'b00_0000_0010,
    S_EROW = 10'b00_0000_0100,
    S_TRD  = 10'b00_0000_1000,
    S_TMAG = 10'b00_0001_0000,
    S_THI  = 10'b00_0010_0000,
    S_TLO  = 10'b00_0100_0000,
    S_TADD = 10'b00_1000_0000,
    S_DIV  = 10'b01_0000_0000,
    S_ETR  = 10'b10_0000_0000
  } state_t;

  state_t st;
  logic [CFG_W-1:0] size_n;
  logic [4:0]       probe_count;
  logic [CW-1:0]    eff_n;
  logic [SW-1:0]    eff_s;

  logic signed [31:0] lval;
  logic [7:0]         lrow, lcol, lmat;
  logic               row_end, mat_end;

  logic [SW-1:0]      ip, tp;
  logic               iss, bv, cv;
  logic [IX-1:0]      bp, cp;
  logic signed [63:0] cprod, pyprod;
  logic signed [63:0] acc [S_MAX];
  logic signed [63:0] row_acc, trace;
  logic [IX-1:0]      acc_sel;
  logic signed [63:0] acc_rd;

  logic [63:0]        ma, phi, plo, mag;
  logic [31:0]        mb;
  logic               neg;
  logic signed [63:0] term, trace_next;
  logic               last_probe;

  logic               ov;
  rsp_item_t          oitem;
  logic               slot_free;

  logic               accept, row_ok, probe_ok, elem_ok;
  logic [AW-1:0]      waddr, vz_raddr, z_raddr;
  logic [31:0]        py_rd, vz_rd, z_rd;
  logic               py_we, vz_we, z_we;

  logic               div_start, div_done;
  logic signed [63:0] div_q;

  always_comb begin
    if (size_n == '0) begin
      eff_n = CW'(1);
    end else if (CW'(size_n) > CW'(N_MAX)) begin
      eff_n = CW'(N_MAX);
    end else begin
      eff_n = CW'(size_n);
    end
    if (probe_count == '0) begin
      eff_s = SW'(1);
    end else if (SW'(probe_count) > SW'(S_MAX)) begin
      eff_s = SW'(S_MAX);
    end else begin
      eff_s = SW'(probe_count);
    end
  end

  assign req.ready = (st == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign row_ok    = CW'(req.item.row) < CW'(N_MAX);
  assign probe_ok  = SXW'(req.item.probe) < SXW'(S_MAX);
  assign elem_ok   = (CW'(req.item.row) < eff_n) && (CW'(req.item.column) < eff_n) &&
                     (XW'(req.item.matrix_index) < XW'(MATRIX_MAX));
  assign waddr     = AW'(AW'(req.item.row) * AW'(S_MAX)) + AW'(req.item.probe);
  assign py_we     = accept && (req.item.opcode == OP_PY) && row_ok;
  assign vz_we     = accept && (req.item.opcode == OP_VINVZ) && row_ok && probe_ok;
  assign z_we      = accept && (req.item.opcode == OP_Z) && row_ok && probe_ok;
  assign vz_raddr  = AW'(AW'(lcol) * AW'(S_MAX)) + AW'(ip[IX-1:0]);
  assign z_raddr   = AW'(AW'(lrow) * AW'(S_MAX)) + AW'(tp[IX-1:0]);

  hmt_ram #(.W(32), .DEPTH(N_MAX), .AW(YW)) u_py (
    .clk, .we(py_we), .waddr(YW'(req.item.row)), .wdata(req.item.value),
    .raddr(YW'(lcol)), .rdata(py_rd)
  );

  hmt_ram #(.W(32), .DEPTH(N_MAX * S_MAX), .AW(AW)) u_vinvz (
    .clk, .we(vz_we), .waddr, .wdata(req.item.value), .raddr(vz_raddr), .rdata(vz_rd)
  );

  hmt_ram #(.W(32), .DEPTH(N_MAX * S_MAX), .AW(AW)) u_z (
    .clk, .we(z_we), .waddr, .wdata(req.item.value), .raddr(z_raddr), .rdata(z_rd)
  );

  assign iss        = (st == S_MAC) && (ip < eff_s);
  assign acc_sel    = (st == S_MAC) ? cp : tp[IX-1:0];
  assign acc_rd     = acc[acc_sel];
  assign last_probe = (tp + SW'(1)) == eff_s;
  assign slot_free  = !ov || rsp.ready;

  always_comb begin
    if (phi[63:47] != '0) begin
      mag = 64'h8000_0000_0000_0000;
    end else begin
      mag = (phi << 16) + (plo >> 16);
    end
    if (neg) begin
      term = mag[63] ? Q_MIN : -$signed(mag);
    end else begin
      term = mag[63] ? Q_MAX : $signed(mag);
    end
    trace_next = sat_add(trace, term);
  end

  assign div_start = (st == S_TADD) && last_probe && mat_end;

  hmt_div #(.VW(SW)) u_div (
    .clk, .rst, .start(div_start), .dividend(trace_next), .divisor(eff_s),
    .done(div_done), .quotient(div_q)
  );

  assign rsp.valid = ov;
  assign rsp.item  = oitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      size_n      <= CFG_W'(256);
      probe_count <= 5'd16;
      bv          <= 1'b0;
      cv          <= 1'b0;
      ov          <= 1'b0;
      row_acc     <= '0;
      trace       <= '0;
      for (int i = 0; i < S_MAX; i++) begin
        acc[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE_N:      size_n <= cfg_data;
          REG_PROBE_COUNT: probe_count <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (ov && rsp.ready && (st != S_EROW) && (st != S_ETR)) begin
        ov <= 1'b0;
      end
      bv <= iss;
      bp <= ip[IX-1:0];
      cv <= bv;
      cp <= bp;
      if (bv) begin
        cprod <= 64'(lval) * 64'($signed(vz_rd));
        if (bp == '0) begin
          pyprod <= 64'(lval) * 64'($signed(py_rd));
        end
      end
      case (st)
        S_IDLE: begin
          if (accept && req.item.opcode == OP_ELEM && elem_ok) begin
            lval    <= req.item.value;
            lrow    <= req.item.row;
            lcol    <= req.item.column;
            lmat    <= req.item.matrix_index;
            row_end <= CW'(req.item.column) == eff_n - CW'(1);
            mat_end <= CW'(req.item.row) == eff_n - CW'(1);
            ip      <= '0;
            st      <= S_MAC;
          end
        end
        S_MAC: begin
          if (iss) begin
            ip <= ip + SW'(1);
          end
          if (cv) begin
            acc[cp] <= sat_add(acc_rd, cprod);
            if (cp == '0) begin
              row_acc <= sat_add(row_acc, pyprod);
            end
          end
          if (!iss && !bv && !cv) begin
            st <= row_end ? S_EROW : S_IDLE;
          end
        end
        S_EROW: begin
          if (slot_free) begin
            ov                 <= 1'b1;
            oitem.kind         <= KIND_PROD;
            oitem.index        <= lrow;
            oitem.result_value <= row_acc;
            oitem.last         <= !mat_end;
            row_acc            <= '0;
            tp                 <= '0;
            st                 <= S_TRD;
          end
        end
        S_TRD: st <= S_TMAG;
        S_TMAG: begin
          neg          <= acc_rd[63] ^ z_rd[31];
          ma           <= acc_rd[63] ? 64'(-acc_rd) : 64'(acc_rd);
          mb           <= z_rd[31] ? -z_rd : z_rd;
          acc[acc_sel] <= '0;
          st           <= S_THI;
        end
        S_THI: begin
          phi <= 64'(ma[63:32]) * 64'(mb);
          st  <= S_TLO;
        end
        S_TLO: begin
          plo <= 64'(ma[31:0]) * 64'(mb);
          st  <= S_TADD;
        end
        S_TADD: begin
          trace <= trace_next;
          tp    <= tp + SW'(1);
          if (!last_probe) begin
            st <= S_TRD;
          end else begin
            st <= mat_end ? S_DIV : S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            lval  <= '0;
            trace <= '0;
            pyprod <= div_q;
            st    <= S_ETR;
          end
        end
        S_ETR: begin
          if (slot_free) begin
            ov                 <= 1'b1;
            oitem.kind         <= KIND_TRACE;
            oitem.index        <= lmat;
            oitem.result_value <= pyprod;
            oitem.last         <= 1'b1;
            st                 <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_idle_drained, req.ready |-> (!bv && !cv), "request taken during accumulation")
  `ASSERT_CLK(a_load_from_emit,
    (ov && !$past(ov)) |-> ($past(st == S_EROW) || $past(st == S_ETR)),
    "result loaded outside an issue state")
  `ASSERT_CLK(a_div_in_wait, div_done |-> (st == S_DIV), "quotient arrived unexpectedly")
  `ASSERT_CLK(a_div_start, div_start |=> (st == S_DIV), "divide started without waiting")

endmodule
`default_nettype wire
